FILE: hdl/lni_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lni_pkg
// Shared types, constants and helper functions for the lattice neighbor
// index generator: widths, register map, pipeline stage records.
// ---------------------------------------------------------------------------
package lni_pkg;

    // Lattice geometry and index width.
    localparam int DIMS       = 4;
    localparam int MAX_DIMS   = 4;
    localparam int INDEX_BITS = 20;
    localparam int EXT_W      = 9;
    localparam int SPLIT_W    = 4;
    localparam int EDGE_W     = 2 * MAX_DIMS;

    // Divider organization: quotient bits resolved per pipeline stage.
    localparam int DIV_BITS        = 4;
    localparam int STAGES_PER_DIV  = (INDEX_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int NDIV            = DIMS * STAGES_PER_DIV;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_RAW_W  = INDEX_BITS;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 2 * MAX_DIMS * INDEX_BITS + EDGE_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_EXTENT_X   = 3'd0,
        REG_EXTENT_Y   = 3'd1,
        REG_EXTENT_Z   = 3'd2,
        REG_EXTENT_T   = 3'd3,
        REG_SPLIT_MASK = 3'd4
    } reg_idx_t;

    typedef logic [EXT_W-1:0]      ext_t;
    typedef logic [INDEX_BITS-1:0] idx_t;

    // Partial remainder and shifting numerator/quotient of one division.
    typedef struct packed {
        ext_t rem;
        idx_t num;
    } div_t;

    // Record carried through the division stages.
    typedef struct packed {
        logic                      valid;
        ext_t                      rem;
        idx_t                      num;
        logic [MAX_DIMS-1:0][EXT_W-1:0] coord;
    } div_stage_t;

    // Record after the coordinate-times-stride products.
    typedef struct packed {
        logic                           valid;
        logic [MAX_DIMS-1:0][EXT_W-1:0] coord;
        logic [MAX_DIMS-1:0][INDEX_BITS-1:0] prod;
    } mul_stage_t;

    // Record holding the reduced site index and boundary flags.
    typedef struct packed {
        logic                valid;
        idx_t                site;
        logic [MAX_DIMS-1:0] top;
        logic [MAX_DIMS-1:0] bot;
    } sum_stage_t;

    // Result record.
    typedef struct packed {
        logic                                valid;
        logic [MAX_DIMS-1:0][INDEX_BITS-1:0] up;
        logic [MAX_DIMS-1:0][INDEX_BITS-1:0] down;
        logic [EDGE_W-1:0]                   edge_mask;
    } out_stage_t;

    // An extent register of zero behaves as extent one.
    function automatic ext_t eff_extent(input ext_t raw);
        eff_extent = (raw == '0) ? ext_t'(1) : raw;
    endfunction

    // Restoring division over up to DIV_BITS quotient bits. first_bit is the
    // count of bits already resolved; steps beyond INDEX_BITS are skipped.
    function automatic div_t div_bits(input div_t a, input ext_t dv,
                                      input int first_bit);
        logic [EXT_W:0] r10;
        div_t           b;
        b = a;
        for (int k = 0; k < DIV_BITS; k++) begin
            if (first_bit + k < INDEX_BITS) begin
                r10   = {b.rem, b.num[INDEX_BITS-1]};
                b.num = {b.num[INDEX_BITS-2:0], 1'b0};
                if (r10 >= {1'b0, dv}) begin
                    b.rem    = EXT_W'(r10 - {1'b0, dv});
                    b.num[0] = 1'b1;
                end else begin
                    b.rem = r10[EXT_W-1:0];
                end
            end
        end
        div_bits = b;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lattice_neighbor_index.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the result stream is not stalled; the
// input register, the 4-bit divider stages, one multiply stage, one sum
// stage and the output register set the depth.
// Each stage holds its item only while the stage after it is full and stalled.
// Reset clears all valid bits and loads extents of 4 and a split mask of 0.
// Stride values derived from the extents are registered and settle after a write.
// ---------------------------------------------------------------------------
// lattice_neighbor_index
// Splits a linear site index of a local 4D block into mixed-radix
// coordinates and produces the up/down neighbor index for each dimension,
// wrapping periodically or flagging off-block neighbors in split dimensions.
// ---------------------------------------------------------------------------
module lattice_neighbor_index
    import lni_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    // Input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // [19:0] site_index

    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata    // [19:0] up_x, [39:20] up_y,
                                              // [59:40] up_z, [79:60] up_t,
                                              // [99:80] down_x, [119:100] down_y,
                                              // [139:120] down_z, [159:140] down_t,
                                              // [167:160] edge_mask
);

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    ext_t               ext_reg [MAX_DIMS];
    logic [SPLIT_W-1:0] split_reg;
    ext_t               ext_eff [MAX_DIMS];
    reg_idx_t           reg_sel;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                ext_reg[d] <= ext_t'(4);
            end
            split_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_EXTENT_X:   ext_reg[0] <= pwdata[EXT_W-1:0];
                REG_EXTENT_Y:   ext_reg[1] <= pwdata[EXT_W-1:0];
                REG_EXTENT_Z:   ext_reg[2] <= pwdata[EXT_W-1:0];
                REG_EXTENT_T:   ext_reg[3] <= pwdata[EXT_W-1:0];
                REG_SPLIT_MASK: split_reg  <= pwdata[SPLIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_EXTENT_X:   prdata = DATA_W'(ext_reg[0]);
            REG_EXTENT_Y:   prdata = DATA_W'(ext_reg[1]);
            REG_EXTENT_Z:   prdata = DATA_W'(ext_reg[2]);
            REG_EXTENT_T:   prdata = DATA_W'(ext_reg[3]);
            REG_SPLIT_MASK: prdata = DATA_W'(split_reg);
            default:        prdata = '0;
        endcase
    end

    // Effective extents: zero counts as one.
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            ext_eff[d] = eff_extent(ext_reg[d]);
        end
    end

    // -----------------------------------------------------------------------
    // Derived strides: stride[d] is the product of the faster extents and
    // span[d] is (extent - 1) * stride, both modulo 2^INDEX_BITS. Each
    // multiply is registered, so the values lag a write to the extents.
    // -----------------------------------------------------------------------
    idx_t stride_reg [MAX_DIMS];
    idx_t span_reg   [MAX_DIMS];

    always_ff @(posedge aclk) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d == DIMS - 1) begin
                stride_reg[d] <= idx_t'(1);
            end else if (d < DIMS - 1) begin
                stride_reg[d] <= stride_reg[d+1] * INDEX_BITS'(ext_eff[d+1]);
            end else begin
                stride_reg[d] <= '0;
            end
            span_reg[d] <= stride_reg[d] * INDEX_BITS'(ext_eff[d] - ext_t'(1));
        end
    end

    // -----------------------------------------------------------------------
    // Pipeline registers and stage enables
    // -----------------------------------------------------------------------
    div_stage_t st_reg  [0:NDIV];
    div_stage_t st_next [0:NDIV];
    mul_stage_t mul_reg;
    mul_stage_t mul_next;
    sum_stage_t sum_reg;
    sum_stage_t sum_next;
    out_stage_t out_reg;
    out_stage_t out_next;
    logic       en [0:NDIV];
    logic       en_mul;
    logic       en_sum;
    logic       en_out;

    // A stage loads when it is empty or the stage after it also moves.
    always_comb begin
        en_out     = !out_reg.valid || m_tready;
        en_sum     = !sum_reg.valid || en_out;
        en_mul     = !mul_reg.valid || en_sum;
        en[NDIV]   = !st_reg[NDIV].valid || en_mul;
        for (int s = NDIV - 1; s >= 0; s--) begin
            en[s] = !st_reg[s].valid || en[s+1];
        end
    end

    assign s_tready = en[0];

    // Input register: the division starts with an empty remainder.
    always_comb begin
        st_next[0].valid = s_tvalid;
        st_next[0].rem   = '0;
        st_next[0].num   = s_tdata[INDEX_BITS-1:0];
        st_next[0].coord = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (en[0]) begin
            st_reg[0] <= st_next[0];
        end
    end

    // -----------------------------------------------------------------------
    // Division stages: the fastest dimension is divided out first. At the
    // last stage of each division the remainder becomes that coordinate and
    // the quotient feeds the next division.
    // -----------------------------------------------------------------------
    for (genvar s = 0; s < NDIV; s++) begin : g_div
        localparam int DD = DIMS - 1 - s / STAGES_PER_DIV;
        localparam int JJ = s % STAGES_PER_DIV;

        div_t step_in;
        div_t step_out;

        always_comb begin
            step_in.rem  = st_reg[s].rem;
            step_in.num  = st_reg[s].num;
            step_out     = div_bits(step_in, ext_eff[DD], JJ * DIV_BITS);
            st_next[s+1] = st_reg[s];
            st_next[s+1].rem = step_out.rem;
            st_next[s+1].num = step_out.num;
            if (JJ == STAGES_PER_DIV - 1) begin
                st_next[s+1].coord[DD] = step_out.rem;
                st_next[s+1].rem       = '0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[s+1].valid <= 1'b0;
            end else if (en[s+1]) begin
                st_reg[s+1] <= st_next[s+1];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Product stage: coordinate times stride for each dimension.
    // -----------------------------------------------------------------------
    always_comb begin
        mul_next.valid = st_reg[NDIV].valid;
        mul_next.coord = st_reg[NDIV].coord;
        for (int d = 0; d < MAX_DIMS; d++) begin
            mul_next.prod[d] = INDEX_BITS'(st_reg[NDIV].coord[d]) * stride_reg[d];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg.valid <= 1'b0;
        end else if (en_mul) begin
            mul_reg <= mul_next;
        end
    end

    // -----------------------------------------------------------------------
    // Sum stage: reduced site index and block-boundary flags.
    // -----------------------------------------------------------------------
    always_comb begin
        sum_next.valid = mul_reg.valid;
        sum_next.site  = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sum_next.site   = sum_next.site + mul_reg.prod[d];
            sum_next.top[d] = (d < DIMS) &&
                              (mul_reg.coord[d] == ext_eff[d] - ext_t'(1));
            sum_next.bot[d] = (d < DIMS) && (mul_reg.coord[d] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg.valid <= 1'b0;
        end else if (en_sum) begin
            sum_reg <= sum_next;
        end
    end

    // -----------------------------------------------------------------------
    // Neighbor stage: step by one stride, wrap by the span, or flag the
    // neighbor as off block in a split dimension.
    // -----------------------------------------------------------------------
    always_comb begin
        out_next.valid     = sum_reg.valid;
        out_next.edge_mask = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d >= DIMS) begin
                out_next.up[d]   = '0;
                out_next.down[d] = '0;
            end else begin
                if (split_reg[d] && sum_reg.top[d]) begin
                    out_next.up[d]        = '1;
                    out_next.edge_mask[d] = 1'b1;
                end else if (sum_reg.top[d]) begin
                    out_next.up[d] = sum_reg.site - span_reg[d];
                end else begin
                    out_next.up[d] = sum_reg.site + stride_reg[d];
                end

                if (split_reg[d] && sum_reg.bot[d]) begin
                    out_next.down[d]                 = '1;
                    out_next.edge_mask[MAX_DIMS + d] = 1'b1;
                end else if (sum_reg.bot[d]) begin
                    out_next.down[d] = sum_reg.site + span_reg[d];
                end else begin
                    out_next.down[d] = sum_reg.site - stride_reg[d];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en_out) begin
            out_reg <= out_next;
        end
    end

    // Result packing, lowest field first.
    always_comb begin
        m_tdata = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            m_tdata[d * INDEX_BITS +: INDEX_BITS]              = out_reg.up[d];
            m_tdata[(MAX_DIMS + d) * INDEX_BITS +: INDEX_BITS] = out_reg.down[d];
        end
        m_tdata[2 * MAX_DIMS * INDEX_BITS +: EDGE_W] = out_reg.edge_mask;
    end

    assign m_tvalid = out_reg.valid;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------

    // With the output register empty, the whole pipeline can move.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_reg.valid |-> s_tready)
        else $error("input not ready although the result register is empty");

    // An accepted item must occupy the first stage on the next cycle.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> st_reg[0].valid)
        else $error("accepted item missing from the first stage");

    // Flagged neighbors must read as all ones.
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_chk
        a_up_off_block: assert property (@(posedge aclk) disable iff (!aresetn)
            (out_reg.valid && out_reg.edge_mask[d]) |-> (out_reg.up[d] == '1))
            else $error("up neighbor flagged off block but index not all ones");

        a_down_off_block: assert property (@(posedge aclk) disable iff (!aresetn)
            (out_reg.valid && out_reg.edge_mask[MAX_DIMS + d]) |->
                (out_reg.down[d] == '1))
            else $error("down neighbor flagged off block but index not all ones");
    end

endmodule
`default_nettype wire
